// ===== rtl/core/nhp_pkg.sv =====
// ----------------------------------------------------------------------------
// nhp_pkg
// shared types, codes and constants of the ntp header parser
// ----------------------------------------------------------------------------
package nhp_pkg;

	localparam int unsigned HDR_BYTES = 48;
	localparam int unsigned POS_W     = 6;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 8;

	localparam logic [2:0] RST_REQ_VERSION  = 3'd4;
	localparam logic [2:0] RST_LOWEST_MODE  = 3'd3;
	localparam logic [2:0] RST_HIGHEST_MODE = 3'd4;
	localparam logic [7:0] RST_MAX_STRATUM  = 8'd16;
	localparam logic [7:0] RST_MAX_POLL     = 8'd17;

	// ascii reference ids of kiss packets
	localparam logic [31:0] KISS_INIT = 32'h494E_4954;
	localparam logic [31:0] KISS_STEP = 32'h5354_4550;
	localparam logic [31:0] KISS_DENY = 32'h4445_4E59;
	localparam logic [31:0] KISS_RATE = 32'h5241_5445;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_REQ_VERSION  = 3'd0,
		CFG_LOWEST_MODE  = 3'd1,
		CFG_HIGHEST_MODE = 3'd2,
		CFG_MAX_STRATUM  = 3'd3,
		CFG_MAX_POLL     = 3'd4
	} nhp_cfg_idx_t;

	typedef enum logic [3:0] {
		OUT_OK        = 4'd0,
		OUT_KISS_INIT = 4'd1,
		OUT_KISS_STEP = 4'd2,
		OUT_KISS_DENY = 4'd3,
		OUT_KISS_RATE = 4'd4,
		OUT_SHORT     = 4'd5,
		OUT_VERSION   = 4'd6,
		OUT_MODE      = 4'd7,
		OUT_STRATUM   = 4'd8,
		OUT_POLL      = 4'd9
	} nhp_outcome_t;

	typedef enum logic [2:0] {
		FLD_FLAGS,
		FLD_STRATUM,
		FLD_POLL,
		FLD_PRECISION,
		FLD_WORD,
		FLD_STAMP,
		FLD_NONE
	} nhp_field_t;

	typedef struct packed {
		logic [2:0] req_version;
		logic [2:0] lowest_mode;
		logic [2:0] highest_mode;
		logic [7:0] max_stratum;
		logic [7:0] max_poll;
	} nhp_cfg_t;

	typedef struct packed {
		logic [7:0] data;
		nhp_field_t kind;
		logic [1:0] sel;
		logic       hdr_done;
		logic       last;
	} nhp_cmd_t;

endpackage

// ===== rtl/core/nhp_ifs.sv =====
// ----------------------------------------------------------------------------
// nhp interfaces
// byte input channel and header result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface nhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface nhp_hdr_if;
	logic        valid;
	logic        ready;
	logic [3:0]  outcome;
	logic [1:0]  leap;
	logic [2:0]  mode;
	logic [7:0]  stratum;
	logic [7:0]  poll;
	logic [31:0] root_delay;
	logic [31:0] root_dispersion;
	logic [31:0] reference_id;
	logic [63:0] reference_time;
	logic [63:0] origin_time;
	logic [63:0] receive_time;
	logic [63:0] transmit_time;

	modport source (
		output valid, output outcome, output leap, output mode, output stratum,
		output poll, output root_delay, output root_dispersion, output reference_id,
		output reference_time, output origin_time, output receive_time,
		output transmit_time, input ready
	);
	modport sink (
		input valid, input outcome, input leap, input mode, input stratum,
		input poll, input root_delay, input root_dispersion, input reference_id,
		input reference_time, input origin_time, input receive_time,
		input transmit_time, output ready
	);
endinterface

// ===== rtl/core/ntp_header_parser_unit.sv =====
// ----------------------------------------------------------------------------
// ntp_header_parser_unit
// Parses the 48-byte ntp header from a udp payload streamed one byte per
// word and returns one result per packet at its last byte. Bytes are taken
// at one per cycle unless stalled, with no gaps between packets; the result
// is registered and held until the sink takes it. Throughput is set by the
// byte-wide front end and the two-entry queue in front of the capture stage;
// the input stalls only once that queue has filled behind a last byte that
// waits for the previous result to be taken. The user writes thresholds
// through the cfg port only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module ntp_header_parser_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [nhp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nhp_pkg::CFG_DAT_W-1:0]  cfg_wdata,
	nhp_byte_if.sink                       ntp_in,
	nhp_hdr_if.source                      ntp_out
);
	import nhp_pkg::*;

	nhp_cfg_t cfg_q;
	nhp_cmd_t front_cmd;
	nhp_cmd_t back_cmd;
	logic     front_valid;
	logic     front_ready;
	logic     back_valid;
	logic     back_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.req_version  <= RST_REQ_VERSION;
			cfg_q.lowest_mode  <= RST_LOWEST_MODE;
			cfg_q.highest_mode <= RST_HIGHEST_MODE;
			cfg_q.max_stratum  <= RST_MAX_STRATUM;
			cfg_q.max_poll     <= RST_MAX_POLL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_REQ_VERSION:  cfg_q.req_version  <= cfg_wdata[2:0];
				CFG_LOWEST_MODE:  cfg_q.lowest_mode  <= cfg_wdata[2:0];
				CFG_HIGHEST_MODE: cfg_q.highest_mode <= cfg_wdata[2:0];
				CFG_MAX_STRATUM:  cfg_q.max_stratum  <= cfg_wdata;
				CFG_MAX_POLL:     cfg_q.max_poll     <= cfg_wdata;
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	nhp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_in   (ntp_in),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready),
		.cmd       (front_cmd)
	);

	nhp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (back_cmd)
	);

	nhp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.cmd       (back_cmd),
		.hdr_out   (ntp_out)
	);

endmodule

// ===== rtl/core/nhp_front.sv =====
// ----------------------------------------------------------------------------
// nhp_front
// accepts payload bytes, tracks the header offset and tags each word
// with the field it belongs to
// ----------------------------------------------------------------------------
module nhp_front (
	input  logic                clk,
	input  logic                arst_n,
	nhp_byte_if.sink            byte_in,
	output logic                cmd_valid,
	input  logic                cmd_ready,
	output nhp_pkg::nhp_cmd_t   cmd
);
	import nhp_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] word_ofs;
	logic [POS_W-1:0] stamp_ofs;
	logic             in_hdr;
	logic             accept;

	assign byte_in.ready = cmd_ready;
	assign cmd_valid     = byte_in.valid;
	assign accept        = byte_in.valid && cmd_ready;
	assign in_hdr        = pos_q < POS_W'(HDR_BYTES);
	assign word_ofs      = pos_q - POS_W'(4);
	assign stamp_ofs     = pos_q - POS_W'(16);

	always_comb begin
		cmd.data     = byte_in.data_byte;
		cmd.last     = byte_in.last_byte;
		cmd.hdr_done = pos_q >= POS_W'(HDR_BYTES - 1);
		cmd.kind     = FLD_NONE;
		cmd.sel      = '0;
		unique case (pos_q) inside
			POS_W'(0): cmd.kind = FLD_FLAGS;
			POS_W'(1): cmd.kind = FLD_STRATUM;
			POS_W'(2): cmd.kind = FLD_POLL;
			POS_W'(3): cmd.kind = FLD_PRECISION;
			[POS_W'(4):POS_W'(15)]: begin
				cmd.kind = FLD_WORD;
				cmd.sel  = word_ofs[3:2];
			end
			[POS_W'(16):POS_W'(HDR_BYTES - 1)]: begin
				cmd.kind = FLD_STAMP;
				cmd.sel  = stamp_ofs[4:3];
			end
			default: cmd.kind = FLD_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (byte_in.last_byte) begin
				pos_q <= '0;
			end else if (in_hdr) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/nhp_queue.sv =====
// ----------------------------------------------------------------------------
// nhp_queue
// two-entry queue of tagged words between front and back end
// ----------------------------------------------------------------------------
module nhp_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push_valid,
	output logic              push_ready,
	input  nhp_pkg::nhp_cmd_t push_cmd,
	output logic              pop_valid,
	input  logic              pop_ready,
	output nhp_pkg::nhp_cmd_t pop_cmd
);
	import nhp_pkg::*;

	nhp_cmd_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_cmd    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/nhp_back.sv =====
// ----------------------------------------------------------------------------
// nhp_back
// captures header fields from tagged words, judges the packet at its
// last word and holds the result until taken
// ----------------------------------------------------------------------------
module nhp_back (
	input  logic              clk,
	input  logic              arst_n,
	input  nhp_pkg::nhp_cfg_t cfg,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  nhp_pkg::nhp_cmd_t cmd,
	nhp_hdr_if.source         hdr_out
);
	import nhp_pkg::*;

	logic [7:0]   flags_q;
	logic [7:0]   stratum_q;
	logic [7:0]   poll_q;
	logic [31:0]  word_q  [3];
	logic [63:0]  stamp_q [4];
	logic         done_q;

	logic [7:0]   flags_nxt;
	logic [7:0]   stratum_nxt;
	logic [7:0]   poll_nxt;
	logic [31:0]  word_nxt  [3];
	logic [63:0]  stamp_nxt [4];
	logic         done_nxt;
	nhp_outcome_t verdict;
	logic [2:0]   version;
	logic [2:0]   mode;
	logic         pop;
	logic         out_valid_q;

	assign cmd_ready = !cmd.last || !out_valid_q || hdr_out.ready;
	assign pop       = cmd_valid && cmd_ready;

	// field values with this word folded in
	always_comb begin
		flags_nxt   = flags_q;
		stratum_nxt = stratum_q;
		poll_nxt    = poll_q;
		word_nxt    = word_q;
		stamp_nxt   = stamp_q;
		done_nxt    = done_q || cmd.hdr_done;
		case (cmd.kind)
			FLD_FLAGS:   flags_nxt   = cmd.data;
			FLD_STRATUM: stratum_nxt = cmd.data;
			FLD_POLL:    poll_nxt    = cmd.data;
			FLD_WORD: begin
				if (cmd.sel != 2'd3) begin
					word_nxt[cmd.sel] = {word_q[cmd.sel][23:0], cmd.data};
				end
			end
			FLD_STAMP:   stamp_nxt[cmd.sel] = {stamp_q[cmd.sel][55:0], cmd.data};
			default:     flags_nxt   = flags_q;
		endcase
	end

	assign version = flags_nxt[5:3];
	assign mode    = flags_nxt[2:0];

	always_comb begin
		verdict = OUT_OK;
		if (!done_nxt) begin
			verdict = OUT_SHORT;
		end else if (version != cfg.req_version) begin
			verdict = OUT_VERSION;
		end else if (mode < cfg.lowest_mode || mode > cfg.highest_mode) begin
			verdict = OUT_MODE;
		end else if (stratum_nxt > cfg.max_stratum) begin
			verdict = OUT_STRATUM;
		end else if (poll_nxt > cfg.max_poll) begin
			verdict = OUT_POLL;
		end else if (stratum_nxt == 8'd0) begin
			if (word_nxt[2] == KISS_INIT) verdict = OUT_KISS_INIT;
			else if (word_nxt[2] == KISS_STEP) verdict = OUT_KISS_STEP;
			else if (word_nxt[2] == KISS_DENY) verdict = OUT_KISS_DENY;
			else if (word_nxt[2] == KISS_RATE) verdict = OUT_KISS_RATE;
		end
	end

	// capture registers, cleared at the end of each packet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q   <= '0;
			stratum_q <= '0;
			poll_q    <= '0;
			word_q    <= '{default: '0};
			stamp_q   <= '{default: '0};
			done_q    <= 1'b0;
		end else if (pop) begin
			if (cmd.last) begin
				flags_q   <= '0;
				stratum_q <= '0;
				poll_q    <= '0;
				word_q    <= '{default: '0};
				stamp_q   <= '{default: '0};
				done_q    <= 1'b0;
			end else begin
				flags_q   <= flags_nxt;
				stratum_q <= stratum_nxt;
				poll_q    <= poll_nxt;
				word_q    <= word_nxt;
				stamp_q   <= stamp_nxt;
				done_q    <= done_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && cmd.last) begin
			out_valid_q <= 1'b1;
		end else if (hdr_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && cmd.last) begin
			hdr_out.outcome         <= verdict;
			hdr_out.leap            <= flags_nxt[7:6];
			hdr_out.mode            <= mode;
			hdr_out.stratum         <= stratum_nxt;
			hdr_out.poll            <= poll_nxt;
			hdr_out.root_delay      <= word_nxt[0];
			hdr_out.root_dispersion <= word_nxt[1];
			hdr_out.reference_id    <= word_nxt[2];
			hdr_out.reference_time  <= stamp_nxt[0];
			hdr_out.origin_time     <= stamp_nxt[1];
			hdr_out.receive_time    <= stamp_nxt[2];
			hdr_out.transmit_time   <= stamp_nxt[3];
		end
	end

	assign hdr_out.valid = out_valid_q;

endmodule

// ===== rtl/core/nhp_checker.sv =====
// ----------------------------------------------------------------------------
// nhp_checker
// port-level checks on the result channel of the ntp header parser
// ----------------------------------------------------------------------------
module nhp_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [3:0]  outcome,
	input  logic [7:0]  stratum,
	input  logic [31:0] reference_id
);
	import nhp_pkg::*;

	logic is_kiss;

	assign is_kiss = outcome == OUT_KISS_INIT || outcome == OUT_KISS_STEP ||
		outcome == OUT_KISS_DENY || outcome == OUT_KISS_RATE;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(outcome) &&
			$stable(reference_id))
		else $error("result dropped or changed while stalled");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> outcome <= OUT_POLL)
		else $error("outcome code out of range");

	a_kiss_stratum: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_kiss |-> stratum == 8'd0)
		else $error("kiss code with nonzero stratum");

	a_kiss_rate: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && outcome == OUT_KISS_RATE |-> reference_id == KISS_RATE)
		else $error("rate kiss without matching reference id");

endmodule

bind ntp_header_parser_unit nhp_checker u_nhp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (ntp_out.valid),
	.out_ready    (ntp_out.ready),
	.outcome      (ntp_out.outcome),
	.stratum      (ntp_out.stratum),
	.reference_id (ntp_out.reference_id)
);

// ===== verif/ntp_header_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp header checker
// Watches the byte and header channels and the cfg port of the ntp header
// parser. It keeps its own copy of the thresholds and of the captured header
// and queues one expected header word per last byte. Each accepted header word
// is compared field by field with the oldest one in the queue. A failure count
// and the number of headers still owed go back to the testbench top.
// ----------------------------------------------------------------------------
module ntp_header_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [nhp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [nhp_pkg::CFG_DAT_W-1:0] cfg_wdata,
	nhp_byte_if                           byte_mon,
	nhp_hdr_if                            hdr_mon,
	output int                            failures,
	output int                            pending,
	output int                            results_seen
);
	import nhp_pkg::*;

	typedef struct packed {
		logic [3:0]  outcome;
		logic [1:0]  leap;
		logic [2:0]  mode;
		logic [7:0]  stratum;
		logic [7:0]  poll;
		logic [31:0] root_delay;
		logic [31:0] root_dispersion;
		logic [31:0] reference_id;
		logic [63:0] reference_time;
		logic [63:0] origin_time;
		logic [63:0] receive_time;
		logic [63:0] transmit_time;
	} ntp_hdr_t;

	nhp_cfg_t         thresholds;
	logic [POS_W-1:0] hdr_pos;
	logic [7:0]       flags_q;
	logic [7:0]       stratum_q;
	logic [7:0]       poll_q;
	logic [31:0]      word_q [3];
	logic [63:0]      stamp_q [4];
	ntp_hdr_t         owed_headers [$];

	task automatic clear_capture();
		hdr_pos   = '0;
		flags_q   = '0;
		stratum_q = '0;
		poll_q    = '0;
		foreach (word_q[i]) word_q[i] = '0;
		foreach (stamp_q[i]) stamp_q[i] = '0;
	endtask

	task automatic take_byte(input logic [7:0] b);
		if (hdr_pos < HDR_BYTES) begin
			if (hdr_pos == 0)
				flags_q = b;
			else if (hdr_pos == 1)
				stratum_q = b;
			else if (hdr_pos == 2)
				poll_q = b;
			else if (hdr_pos >= 4 && hdr_pos < 16)
				word_q[(hdr_pos - 4) >> 2] = {word_q[(hdr_pos - 4) >> 2][23:0], b};
			else if (hdr_pos >= 16)
				stamp_q[(hdr_pos - 16) >> 3] = {stamp_q[(hdr_pos - 16) >> 3][55:0], b};
			hdr_pos++;
		end
	endtask

	function automatic nhp_outcome_t verdict();
		logic [2:0] ver;
		logic [2:0] md;
		ver = flags_q[5:3];
		md  = flags_q[2:0];
		if (hdr_pos < HDR_BYTES) return OUT_SHORT;
		if (ver != thresholds.req_version) return OUT_VERSION;
		if (md < thresholds.lowest_mode || md > thresholds.highest_mode) return OUT_MODE;
		if (stratum_q > thresholds.max_stratum) return OUT_STRATUM;
		if (poll_q > thresholds.max_poll) return OUT_POLL;
		if (stratum_q == 0) begin
			case (word_q[2])
				KISS_INIT: return OUT_KISS_INIT;
				KISS_STEP: return OUT_KISS_STEP;
				KISS_DENY: return OUT_KISS_DENY;
				KISS_RATE: return OUT_KISS_RATE;
				default: ;
			endcase
		end
		return OUT_OK;
	endfunction

	function automatic ntp_hdr_t predicted_header();
		ntp_hdr_t h;
		h.outcome         = verdict();
		h.leap            = flags_q[7:6];
		h.mode            = flags_q[2:0];
		h.stratum         = stratum_q;
		h.poll            = poll_q;
		h.root_delay      = word_q[0];
		h.root_dispersion = word_q[1];
		h.reference_id    = word_q[2];
		h.reference_time  = stamp_q[0];
		h.origin_time     = stamp_q[1];
		h.receive_time    = stamp_q[2];
		h.transmit_time   = stamp_q[3];
		return h;
	endfunction

	function automatic string describe(input ntp_hdr_t h);
		return $sformatf({"outcome=%0d leap=%0d mode=%0d stratum=%0d poll=%0d ",
			"delay=%h disp=%h ref=%h ts=%h %h %h %h"},
			h.outcome, h.leap, h.mode, h.stratum, h.poll, h.root_delay,
			h.root_dispersion, h.reference_id, h.reference_time, h.origin_time,
			h.receive_time, h.transmit_time);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ntp_hdr_t got;
		ntp_hdr_t want;
		if (!arst_n) begin
			thresholds = '{req_version: RST_REQ_VERSION, lowest_mode: RST_LOWEST_MODE,
				highest_mode: RST_HIGHEST_MODE, max_stratum: RST_MAX_STRATUM,
				max_poll: RST_MAX_POLL};
			clear_capture();
			owed_headers.delete();
			failures     = 0;
			results_seen = 0;
		end else begin
			// header word leaving the block
			if (hdr_mon.valid && hdr_mon.ready) begin
				got.outcome         = hdr_mon.outcome;
				got.leap            = hdr_mon.leap;
				got.mode            = hdr_mon.mode;
				got.stratum         = hdr_mon.stratum;
				got.poll            = hdr_mon.poll;
				got.root_delay      = hdr_mon.root_delay;
				got.root_dispersion = hdr_mon.root_dispersion;
				got.reference_id    = hdr_mon.reference_id;
				got.reference_time  = hdr_mon.reference_time;
				got.origin_time     = hdr_mon.origin_time;
				got.receive_time    = hdr_mon.receive_time;
				got.transmit_time   = hdr_mon.transmit_time;
				results_seen++;
				if (owed_headers.size() == 0) begin
					if (failures < 10)
						$display("unexpected header word: %s", describe(got));
					failures++;
				end else begin
					want = owed_headers.pop_front();
					if (got.outcome !== want.outcome || got.leap !== want.leap ||
					    got.mode !== want.mode || got.stratum !== want.stratum ||
					    got.poll !== want.poll || got.root_delay !== want.root_delay ||
					    got.root_dispersion !== want.root_dispersion ||
					    got.reference_id !== want.reference_id ||
					    got.reference_time !== want.reference_time ||
					    got.origin_time !== want.origin_time ||
					    got.receive_time !== want.receive_time ||
					    got.transmit_time !== want.transmit_time) begin
						if (failures < 10) begin
							$display("header %0d mismatch", results_seen);
							$display("  expected %s", describe(want));
							$display("  actual   %s", describe(got));
						end
						failures++;
					end
				end
			end
			// payload byte entering the block
			if (byte_mon.valid && byte_mon.ready) begin
				take_byte(byte_mon.data_byte);
				if (byte_mon.last_byte) begin
					owed_headers.push_back(predicted_header());
					clear_capture();
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_REQ_VERSION:  thresholds.req_version  = cfg_wdata[2:0];
					CFG_LOWEST_MODE:  thresholds.lowest_mode  = cfg_wdata[2:0];
					CFG_HIGHEST_MODE: thresholds.highest_mode = cfg_wdata[2:0];
					CFG_MAX_STRATUM:  thresholds.max_stratum  = cfg_wdata;
					CFG_MAX_POLL:     thresholds.max_poll     = cfg_wdata;
					default: ;
				endcase
			end
		end
		pending = owed_headers.size();
	end

endmodule

// ===== verif/ntp_header_parser_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntp_header_parser_unit_tb
// Streams udp payloads byte by byte into the ntp header parser: a directed
// set of headers for each outcome, field extremes, short and long packets,
// then random packets over several threshold settings, zero, full-scale and
// an inverted mode range among them. Both handshake sides idle at random, the
// result side also holds off for a long stretch. Checking is done by the
// header checker instantiated beside the block.
// ----------------------------------------------------------------------------
module ntp_header_parser_unit_tb;
	import nhp_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_BYTES = 320;
	localparam int PHASES       = 8;
	localparam int HOLD_CYCLES  = 400;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_wdata;

	nhp_byte_if byte_ch();
	nhp_hdr_if  hdr_ch();

	int failures;
	int pending;
	int results_seen;
	int cycle_cnt    = 0;
	int bytes_sent   = 0;
	int packets_sent = 0;
	int settings     = 1;

	logic     steady  = 1'b0;
	logic     rx_hold = 1'b0;
	logic     hold_go = 1'b0;
	nhp_cfg_t cur_cfg;

	always #5 clk = ~clk;

	ntp_header_parser_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.ntp_in    (byte_ch),
		.ntp_out   (hdr_ch)
	);

	ntp_header_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.byte_mon     (byte_ch),
		.hdr_mon      (hdr_ch),
		.failures     (failures),
		.pending      (pending),
		.results_seen (results_seen)
	);

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			byte_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= fin;
		do @(posedge clk); while (!(byte_ch.valid && byte_ch.ready));
		bytes_sent++;
	endtask

	task automatic send_packet(input int len, input fill_t fill, input logic [7:0] flags,
		input logic [7:0] stratum, input logic [7:0] poll, input logic [31:0] ref_id);
		logic [7:0] hdr [HDR_BYTES];
		logic [7:0] b;
		for (int i = 0; i < HDR_BYTES; i++) begin
			case (fill)
				FILL_ZERO: hdr[i] = 8'h00;
				FILL_ONES: hdr[i] = 8'hFF;
				default:   hdr[i] = 8'($urandom);
			endcase
		end
		hdr[0] = flags;
		hdr[1] = stratum;
		hdr[2] = poll;
		for (int k = 0; k < 4; k++)
			hdr[12 + k] = ref_id[31 - 8 * k -: 8];
		for (int i = 0; i < len; i++) begin
			b = (i < HDR_BYTES) ? hdr[i] : 8'($urandom);
			send_byte(b, i == len - 1);
		end
		packets_sent++;
	endtask

	task automatic random_packet();
		int          len;
		logic [2:0]  ver;
		logic [2:0]  md;
		logic [7:0]  st;
		logic [7:0]  pl;
		logic [31:0] rid;
		case ($urandom_range(0, 9))
			0, 1:    len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 47)
				: $urandom_range(1, 6);
			2:       len = $urandom_range(49, 64);
			default: len = HDR_BYTES;
		endcase
		ver = ($urandom_range(0, 9) < 8) ? cur_cfg.req_version : 3'($urandom);
		if (cur_cfg.lowest_mode <= cur_cfg.highest_mode && $urandom_range(0, 9) < 8)
			md = 3'($urandom_range(cur_cfg.lowest_mode, cur_cfg.highest_mode));
		else
			md = 3'($urandom);
		case ($urandom_range(0, 9))
			0, 1, 2: st = 8'h00;
			8, 9:    st = 8'($urandom);
			default: st = 8'($urandom_range(0, cur_cfg.max_stratum));
		endcase
		pl = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, cur_cfg.max_poll))
			: 8'($urandom);
		case ($urandom_range(0, 7))
			0:       rid = KISS_INIT;
			1:       rid = KISS_STEP;
			2:       rid = KISS_DENY;
			3:       rid = KISS_RATE;
			default: rid = $urandom;
		endcase
		send_packet(len, FILL_RANDOM, {2'($urandom), ver, md}, st, pl, rid);
	endtask

	// wait until every owed header word has come back
	task automatic drain();
		byte_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		@(posedge clk);
	endtask

	task automatic apply_cfg(input nhp_cfg_t c);
		write_reg(CFG_REQ_VERSION, {5'($urandom), c.req_version});
		write_reg(CFG_LOWEST_MODE, {5'($urandom), c.lowest_mode});
		write_reg(CFG_HIGHEST_MODE, {5'($urandom), c.highest_mode});
		write_reg(CFG_MAX_STRATUM, c.max_stratum);
		write_reg(CFG_MAX_POLL, c.max_poll);
		// index past the last register must be ignored
		write_reg(CFG_IDX_W'(CFG_MAX_POLL) + CFG_IDX_W'($urandom_range(1, 3)),
			8'($urandom));
		cfg_we  <= 1'b0;
		cur_cfg = c;
		settings++;
	endtask

	function automatic nhp_cfg_t rand_cfg();
		nhp_cfg_t c;
		c.req_version  = 3'($urandom);
		c.lowest_mode  = 3'($urandom_range(0, 4));
		c.highest_mode = 3'($urandom_range(c.lowest_mode, 7));
		c.max_stratum  = 8'($urandom);
		c.max_poll     = 8'($urandom);
		return c;
	endfunction

	// result side: random stalls, long hold-off on request
	initial begin
		int gap;
		hdr_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 7);
			if (gap != 0 || rx_hold) begin
				hdr_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
				while (rx_hold) @(posedge clk);
			end
			hdr_ch.ready <= 1'b1;
			do @(posedge clk); while (!(hdr_ch.valid && hdr_ch.ready));
		end
	end

	initial begin
		do @(posedge clk); while (!hold_go);
		rx_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		rx_hold <= 1'b0;
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("timeout after %0d cycles, %0d headers still owed", cycle_cnt, pending);
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [7:0] good;
		nhp_cfg_t   c;
		int         start;
		arst_n            <= 1'b0;
		cfg_we            <= 1'b0;
		cfg_index         <= '0;
		cfg_wdata         <= '0;
		byte_ch.valid     <= 1'b0;
		byte_ch.data_byte <= '0;
		byte_ch.last_byte <= 1'b0;
		cur_cfg = '{req_version: RST_REQ_VERSION, lowest_mode: RST_LOWEST_MODE,
			highest_mode: RST_HIGHEST_MODE, max_stratum: RST_MAX_STRATUM,
			max_poll: RST_MAX_POLL};
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed headers against the reset thresholds
		good = {2'd1, RST_REQ_VERSION, RST_LOWEST_MODE};
		send_packet(48, FILL_ZERO, {2'd0, RST_REQ_VERSION, RST_LOWEST_MODE}, 0, 0, 0);
		send_packet(48, FILL_ONES, {2'd3, RST_REQ_VERSION, RST_HIGHEST_MODE},
			RST_MAX_STRATUM, RST_MAX_POLL, '1);
		send_packet(48, FILL_RANDOM, good, 0, 6, KISS_INIT);
		send_packet(48, FILL_RANDOM, good, 0, 6, KISS_STEP);
		send_packet(48, FILL_RANDOM, good, 0, 6, KISS_DENY);
		send_packet(48, FILL_RANDOM, good, 0, 6, KISS_RATE);
		send_packet(48, FILL_RANDOM, good, 1, 6, KISS_RATE);
		send_packet(1, FILL_RANDOM, good, 2, 6, 0);
		send_packet(3, FILL_RANDOM, good, 2, 6, 0);
		send_packet(47, FILL_ONES, good, 2, 6, KISS_INIT);
		send_packet(48, FILL_RANDOM, {2'd2, 3'd3, RST_LOWEST_MODE}, 2, 6, 0);
		send_packet(48, FILL_RANDOM, {2'd2, 3'd5, 3'd7}, 2, 6, 0);
		send_packet(48, FILL_RANDOM, {2'd0, RST_REQ_VERSION, 3'd2}, 2, 6, 0);
		send_packet(48, FILL_RANDOM, {2'd0, RST_REQ_VERSION, 3'd5}, 2, 6, 0);
		send_packet(48, FILL_RANDOM, good, RST_MAX_STRATUM + 8'd1, 6, 0);
		send_packet(48, FILL_RANDOM, good, 8'hFF, 8'hFF, 0);
		send_packet(48, FILL_RANDOM, good, 0, RST_MAX_POLL + 8'd1, KISS_INIT);
		send_packet(64, FILL_RANDOM, good, 3, 6, 0);
		drain();

		// random packets over several threshold settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: c = cur_cfg;
				1: c = '0;
				2: c = '1;
				3: begin
					c = rand_cfg();
					c.lowest_mode  = 3'd6;
					c.highest_mode = 3'd1;
				end
				default: c = rand_cfg();
			endcase
			apply_cfg(c);
			steady <= (ph == 2 || ph == 5);
			if (ph == 5) begin
				hold_go <= 1'b1;
				// burst of one-byte packets so results back up and the input stalls
				repeat (6) send_packet(1, FILL_RANDOM, good, 0, 0, 0);
			end
			start = bytes_sent;
			while (bytes_sent - start < RANDOM_BYTES / PHASES)
				random_packet();
			drain();
		end

		repeat (10) @(posedge clk);
		$display("covered %0d payload bytes in %0d packets, %0d header words checked",
			bytes_sent, packets_sent, results_seen);
		$display("%0d threshold settings incl. zero, full-scale, inverted mode range; %0d cycles",
			settings, cycle_cnt);
		if (failures == 0 && pending == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
